// ===== design/tbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared constants, types and helpers of the barycentric coordinate unit.
// ----------------------------------------------------------------------------
package tbc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int RES_WIDTH       = 32;

   // Sideband that travels down the divider chain with each item
   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic ovf_a;
      logic ovf_b;
      logic degen;
   } ctrl_type;

   // Apply sign to a quotient magnitude (or 2^32 on overflow), saturate to 32 bits
   function automatic logic signed [RES_WIDTH-1:0] sign_sat(
      input logic [RES_WIDTH-1:0] q,
      input logic                 neg,
      input logic                 ovf
   );
      logic [RES_WIDTH+1:0]        mag;
      logic signed [RES_WIDTH+1:0] val;
      logic signed [RES_WIDTH+1:0] lim_hi;
      logic signed [RES_WIDTH+1:0] lim_lo;
      mag    = ovf ? ((RES_WIDTH+2)'(1) << RES_WIDTH) : {2'b00, q};
      val    = neg ? -$signed(mag) : $signed(mag);
      lim_hi = (RES_WIDTH+2)'(signed'({1'b0, {(RES_WIDTH-1){1'b1}}}));
      lim_lo = -((RES_WIDTH+2)'(signed'(1)) <<< (RES_WIDTH-1));
      if (val > lim_hi)      sign_sat = lim_hi[RES_WIDTH-1:0];
      else if (val < lim_lo) sign_sat = lim_lo[RES_WIDTH-1:0];
      else                   sign_sat = val[RES_WIDTH-1:0];
   endfunction

endpackage

// ===== design/tbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_front
// Edge vectors, cross products, magnitudes and overflow pre-check (3 stages).
// ----------------------------------------------------------------------------
module tbc_front import tbc_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int FB = FRAC_BITS_DEF,
   localparam int DW = CW + 1,
   localparam int PW = 2 * DW,
   localparam int MW = PW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [CW-1:0] px,
   input  logic signed [CW-1:0] py,
   input  logic signed [CW-1:0] ax,
   input  logic signed [CW-1:0] ay,
   input  logic signed [CW-1:0] bx,
   input  logic signed [CW-1:0] by,
   input  logic signed [CW-1:0] cx,
   input  logic signed [CW-1:0] cy,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [MW+FB-1:0]     rem_a,
   output logic [MW+FB-1:0]     rem_b,
   output logic [MW-1:0]        den,
   output ctrl_type             ctrl
);

   localparam int KW = MW + RES_WIDTH;

   logic v1_ff, v2_ff, v3_ff;
   logic r1, r2, r3;

   logic signed [DW-1:0] qx_ff, qy_ff, mx_ff, my_ff, nx_ff, ny_ff;
   logic signed [PW-1:0] p_d1_ff, p_d2_ff, p_a1_ff, p_a2_ff, p_b1_ff, p_b2_ff;
   logic [MW-1:0]        an_ff, bn_ff, ad_ff;
   ctrl_type             ctrl_ff;

   logic signed [MW-1:0] d_s, na_s, nb_s;
   logic [MW-1:0]        an_in, bn_in, ad_in;
   ctrl_type             ctrl_in;

   // stage handshake, a full stage holds while its successor cannot advance
   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   // stage 1: vectors relative to vertex C
   always_ff @(posedge clock) begin
      if (r1) begin
         qx_ff <= DW'(px) - DW'(cx);
         qy_ff <= DW'(py) - DW'(cy);
         mx_ff <= DW'(ax) - DW'(cx);
         my_ff <= DW'(ay) - DW'(cy);
         nx_ff <= DW'(bx) - DW'(cx);
         ny_ff <= DW'(by) - DW'(cy);
      end
   end

   // stage 2: the six partial products
   always_ff @(posedge clock) begin
      if (r2) begin
         p_d1_ff <= PW'(mx_ff) * PW'(ny_ff);
         p_d2_ff <= PW'(my_ff) * PW'(nx_ff);
         p_a1_ff <= PW'(qx_ff) * PW'(ny_ff);
         p_a2_ff <= PW'(qy_ff) * PW'(nx_ff);
         p_b1_ff <= PW'(mx_ff) * PW'(qy_ff);
         p_b2_ff <= PW'(my_ff) * PW'(qx_ff);
      end
   end

   // stage 3: cross products, magnitudes, signs and overflow pre-check
   always_comb begin
      d_s  = MW'(p_d1_ff) - MW'(p_d2_ff);
      na_s = MW'(p_a1_ff) - MW'(p_a2_ff);
      nb_s = MW'(p_b1_ff) - MW'(p_b2_ff);
      an_in = na_s[MW-1] ? MW'(-na_s) : MW'(na_s);
      bn_in = nb_s[MW-1] ? MW'(-nb_s) : MW'(nb_s);
      ad_in = d_s[MW-1]  ? MW'(-d_s)  : MW'(d_s);
      ctrl_in.neg_a = na_s[MW-1] ^ d_s[MW-1];
      ctrl_in.neg_b = nb_s[MW-1] ^ d_s[MW-1];
      // quotient reaches 2^32 when num * 2^FB >= den * 2^32
      ctrl_in.ovf_a = ((KW'(an_in) << FB) >= (KW'(ad_in) << RES_WIDTH));
      ctrl_in.ovf_b = ((KW'(bn_in) << FB) >= (KW'(ad_in) << RES_WIDTH));
      ctrl_in.degen = (d_s == '0);
   end

   always_ff @(posedge clock) begin
      if (r3) begin
         an_ff   <= an_in;
         bn_ff   <= bn_in;
         ad_ff   <= ad_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign out_valid = v3_ff;
   assign rem_a     = (MW+FB)'(an_ff) << FB;
   assign rem_b     = (MW+FB)'(bn_ff) << FB;
   assign den       = ad_ff;
   assign ctrl      = ctrl_ff;

endmodule

// ===== design/tbc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_div_cell
// One restoring division step for both weights; resolves quotient bit BIT.
// ----------------------------------------------------------------------------
module tbc_div_cell import tbc_pkg::*; #(
   parameter int MW  = 35,
   parameter int FB  = FRAC_BITS_DEF,
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [MW+FB-1:0]     in_rem_a,
   input  logic [MW+FB-1:0]     in_rem_b,
   input  logic [MW-1:0]        in_den,
   input  logic [RES_WIDTH-1:0] in_q_a,
   input  logic [RES_WIDTH-1:0] in_q_b,
   input  ctrl_type             in_ctrl,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [MW+FB-1:0]     out_rem_a,
   output logic [MW+FB-1:0]     out_rem_b,
   output logic [MW-1:0]        out_den,
   output logic [RES_WIDTH-1:0] out_q_a,
   output logic [RES_WIDTH-1:0] out_q_b,
   output ctrl_type             out_ctrl
);

   localparam int W = MW + FB;

   logic                 v_ff;
   logic [W-1:0]         rem_a_ff, rem_b_ff, rem_a_in, rem_b_in;
   logic [MW-1:0]        den_ff;
   logic [RES_WIDTH-1:0] q_a_ff, q_b_ff, q_a_in, q_b_in;
   ctrl_type             ctrl_ff;
   logic [W-1:0]         den_w;
   logic                 ge_a, ge_b;

   assign in_ready = !v_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
   end

   // trial subtract of den * 2^BIT
   always_comb begin
      den_w    = W'(in_den);
      ge_a     = (in_rem_a >> BIT) >= den_w;
      ge_b     = (in_rem_b >> BIT) >= den_w;
      rem_a_in = ge_a ? in_rem_a - (den_w << BIT) : in_rem_a;
      rem_b_in = ge_b ? in_rem_b - (den_w << BIT) : in_rem_b;
      q_a_in   = in_q_a;
      q_b_in   = in_q_b;
      q_a_in[BIT] = ge_a;
      q_b_in[BIT] = ge_b;
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
         den_ff   <= in_den;
         q_a_ff   <= q_a_in;
         q_b_ff   <= q_b_in;
         ctrl_ff  <= in_ctrl;
      end
   end

   assign out_valid = v_ff;
   assign out_rem_a = rem_a_ff;
   assign out_rem_b = rem_b_ff;
   assign out_den   = den_ff;
   assign out_q_a   = q_a_ff;
   assign out_q_b   = q_b_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

// ===== design/triangle_barycentric_coords_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_coords_unit
// Barycentric weights of a sample point against a 2D triangle.
// ----------------------------------------------------------------------------
// One sample point with its triangle is taken every cycle unless the
// pipeline is stalled by rsp_ready; each result passes 36 register stages
// (3 front stages, a chain of 32 divider cells, one for each quotient bit,
// shared by the alpha and beta lanes, and one output register), with one
// cell per result bit. A zero determinant returns zero weights with
// degenerate set.
module triangle_barycentric_coords_unit import tbc_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int RESULT_FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_vert_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_vert_c_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [RES_WIDTH-1:0] rsp_alpha,
   output logic signed [RES_WIDTH-1:0] rsp_beta,
   output logic signed [RES_WIDTH-1:0] rsp_gamma,
   output logic                        rsp_inside_res,
   output logic                        rsp_degenerate
);

   localparam int MW = 2 * (COORD_WIDTH + 1) + 1;
   localparam int W  = MW + RESULT_FRAC_BITS;
   localparam int NC = RES_WIDTH;

   // chain links: index 0 is the front output, index NC the last cell output
   logic                 lk_valid [NC+1];
   logic                 lk_ready [NC+1];
   logic [W-1:0]         lk_rem_a [NC+1];
   logic [W-1:0]         lk_rem_b [NC+1];
   logic [MW-1:0]        lk_den   [NC+1];
   logic [RES_WIDTH-1:0] lk_q_a   [NC+1];
   logic [RES_WIDTH-1:0] lk_q_b   [NC+1];
   ctrl_type             lk_ctrl  [NC+1];

   tbc_front #(
      .CW (COORD_WIDTH),
      .FB (RESULT_FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .px        (req_point_x),
      .py        (req_point_y),
      .ax        (req_vert_a_x),
      .ay        (req_vert_a_y),
      .bx        (req_vert_b_x),
      .by        (req_vert_b_y),
      .cx        (req_vert_c_x),
      .cy        (req_vert_c_y),
      .out_valid (lk_valid[0]),
      .out_ready (lk_ready[0]),
      .rem_a     (lk_rem_a[0]),
      .rem_b     (lk_rem_b[0]),
      .den       (lk_den[0]),
      .ctrl      (lk_ctrl[0])
   );

   assign lk_q_a[0] = '0;
   assign lk_q_b[0] = '0;

   // divider chain, most significant quotient bit first
   for (genvar i = 0; i < NC; i++) begin : g_cell
      tbc_div_cell #(
         .MW  (MW),
         .FB  (RESULT_FRAC_BITS),
         .BIT (NC - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lk_valid[i]),
         .in_ready  (lk_ready[i]),
         .in_rem_a  (lk_rem_a[i]),
         .in_rem_b  (lk_rem_b[i]),
         .in_den    (lk_den[i]),
         .in_q_a    (lk_q_a[i]),
         .in_q_b    (lk_q_b[i]),
         .in_ctrl   (lk_ctrl[i]),
         .out_valid (lk_valid[i+1]),
         .out_ready (lk_ready[i+1]),
         .out_rem_a (lk_rem_a[i+1]),
         .out_rem_b (lk_rem_b[i+1]),
         .out_den   (lk_den[i+1]),
         .out_q_a   (lk_q_a[i+1]),
         .out_q_b   (lk_q_b[i+1]),
         .out_ctrl  (lk_ctrl[i+1])
      );
   end

   // output stage: sign, saturation, gamma and flags
   logic                        out_v_ff;
   logic signed [RES_WIDTH-1:0] al_ff, be_ff, ga_ff, al_in, be_in, ga_in;
   logic                        ins_ff, deg_ff, ins_in, deg_in;
   logic signed [RES_WIDTH+1:0] ga_w;
   ctrl_type                    c_last;

   assign lk_ready[NC] = !out_v_ff || rsp_ready;
   assign c_last       = lk_ctrl[NC];

   always_comb begin
      al_in = sign_sat(lk_q_a[NC], c_last.neg_a, c_last.ovf_a);
      be_in = sign_sat(lk_q_b[NC], c_last.neg_b, c_last.ovf_b);
      ga_w  = ((RES_WIDTH+2)'(signed'(1)) <<< RESULT_FRAC_BITS)
            - (RES_WIDTH+2)'(al_in) - (RES_WIDTH+2)'(be_in);
      if (ga_w > (RES_WIDTH+2)'(signed'({1'b0, {(RES_WIDTH-1){1'b1}}})))
         ga_in = {1'b0, {(RES_WIDTH-1){1'b1}}};
      else if (ga_w < -((RES_WIDTH+2)'(signed'(1)) <<< (RES_WIDTH-1)))
         ga_in = {1'b1, {(RES_WIDTH-1){1'b0}}};
      else
         ga_in = ga_w[RES_WIDTH-1:0];
      ins_in = !al_in[RES_WIDTH-1] && !be_in[RES_WIDTH-1] && !ga_in[RES_WIDTH-1];
      deg_in = c_last.degen;
      if (c_last.degen) begin
         al_in  = '0;
         be_in  = '0;
         ga_in  = '0;
         ins_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (lk_ready[NC]) out_v_ff <= lk_valid[NC];
   end

   always_ff @(posedge clock) begin
      if (lk_ready[NC]) begin
         al_ff  <= al_in;
         be_ff  <= be_in;
         ga_ff  <= ga_in;
         ins_ff <= ins_in;
         deg_ff <= deg_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_alpha      = al_ff;
   assign rsp_beta       = be_ff;
   assign rsp_gamma      = ga_ff;
   assign rsp_inside_res = ins_ff;
   assign rsp_degenerate = deg_ff;

endmodule

// ===== design/tbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks of the barycentric coordinate unit, bound to the top.
// ----------------------------------------------------------------------------
module tbc_checker import tbc_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [RES_WIDTH-1:0] rsp_alpha,
   input logic signed [RES_WIDTH-1:0] rsp_beta,
   input logic signed [RES_WIDTH-1:0] rsp_gamma,
   input logic                        rsp_inside_res,
   input logic                        rsp_degenerate
);

   // no result shows right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds valid, alpha and gamma
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alpha) && $stable(rsp_gamma))
      else $error("stalled result changed");

   // degenerate triangle gives zero weights and outside
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_alpha == '0 && rsp_beta == '0 && rsp_gamma == '0 && !rsp_inside_res)
      else $error("degenerate result not cleared");

   // inside only with non-negative weights
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |->
         !rsp_alpha[RES_WIDTH-1] && !rsp_beta[RES_WIDTH-1] && !rsp_gamma[RES_WIDTH-1])
      else $error("inside flag with negative weight");

endmodule

bind triangle_barycentric_coords_unit tbc_checker u_tbc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_alpha      (rsp_alpha),
   .rsp_beta       (rsp_beta),
   .rsp_gamma      (rsp_gamma),
   .rsp_inside_res (rsp_inside_res),
   .rsp_degenerate (rsp_degenerate)
);

// ===== bench/tb_triangle_barycentric_coords_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_barycentric_coords_unit
// Self-checking bench for the barycentric coordinate unit.
// ----------------------------------------------------------------------------
// Sample points and triangles are sent over the request channel. A behavioral
// predictor works out the Q16.16 weights, the inside flag and the degenerate
// flag of each transfer. Results are matched in order against that queue.
// Both channels idle and stall at random.
module tb_triangle_barycentric_coords_unit;
   import tbc_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int FB        = FRAC_BITS_DEF;
   localparam int LATENCY   = 36;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1080;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic signed [RES_WIDTH-1:0] alpha;
      logic signed [RES_WIDTH-1:0] beta;
      logic signed [RES_WIDTH-1:0] gamma;
      logic                        inside_res;
      logic                        degenerate;
   } weights_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_point_x = '0, req_point_y = '0;
   coord_type req_vert_a_x = '0, req_vert_a_y = '0;
   coord_type req_vert_b_x = '0, req_vert_b_y = '0;
   coord_type req_vert_c_x = '0, req_vert_c_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic signed [RES_WIDTH-1:0] rsp_alpha, rsp_beta, rsp_gamma;
   logic      rsp_inside_res, rsp_degenerate;

   weights_type expected_weights[$];
   int       n_errors = 0;
   int       n_sent = 0;
   int       n_checked = 0;
   int       n_degen = 0;
   int       n_inside = 0;
   int       n_sat = 0;
   int       idle_cycles = 0;
   bit       rsp_stall_on = 1'b1;

   triangle_barycentric_coords_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // trunc(num * 2^FB / den), magnitude capped at 2^32
   function automatic longint weight_ratio(longint num, longint den);
      bit     neg;
      longint an, ad, ip, rem, mag;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      ip  = an / ad;
      rem = an % ad;
      if (ip >= (64'sd1 << (32 - FB))) begin
         mag = 64'sd1 << 32;
      end else begin
         mag = ip;
         for (int i = 0; i < FB; i++) begin
            rem = rem << 1;
            mag = mag << 1;
            if (rem >= ad) begin
               rem = rem - ad;
               mag = mag | 1;
            end
         end
      end
      return neg ? -mag : mag;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Predicted weights of point p in triangle a, b, c
   function automatic weights_type predict_weights(coord_type px, coord_type py,
                                                   coord_type ax, coord_type ay,
                                                   coord_type bx, coord_type by,
                                                   coord_type cx, coord_type cy);
      weights_type w;
      longint      qx, qy, mx, my, nx, ny, det, al, be, ga;
      qx = px - cx;  qy = py - cy;
      mx = ax - cx;  my = ay - cy;
      nx = bx - cx;  ny = by - cy;
      det = mx * ny - my * nx;
      w = '0;
      if (det == 0) begin
         w.degenerate = 1'b1;
         return w;
      end
      al = clamp32(weight_ratio(qx * ny - qy * nx, det));
      be = clamp32(weight_ratio(mx * qy - my * qx, det));
      ga = clamp32((64'sd1 <<< FB) - al - be);
      w.alpha      = al[31:0];
      w.beta       = be[31:0];
      w.gamma      = ga[31:0];
      w.inside_res = (al >= 0) && (be >= 0) && (ga >= 0);
      return w;
   endfunction

   // Send one point and triangle, then wait for its transfer
   task automatic send_sample(coord_type px, coord_type py, coord_type ax, coord_type ay,
                              coord_type bx, coord_type by, coord_type cx, coord_type cy);
      weights_type w;
      w = predict_weights(px, py, ax, ay, bx, by, cx, cy);
      req_valid    <= 1'b1;
      req_point_x  <= px;  req_point_y  <= py;
      req_vert_a_x <= ax;  req_vert_a_y <= ay;
      req_vert_b_x <= bx;  req_vert_b_y <= by;
      req_vert_c_x <= cx;  req_vert_c_y <= cy;
      do @(posedge clock); while (!req_ready);
      expected_weights.push_back(w);
      n_sent++;
      if (w.degenerate) n_degen++;
      if (w.inside_res) n_inside++;
      if (w.alpha == 32'sh7FFFFFFF || w.alpha == 32'sh80000000) n_sat++;
   endtask

   task automatic send_with_gap(coord_type px, coord_type py, coord_type ax, coord_type ay,
                                coord_type bx, coord_type by, coord_type cx, coord_type cy);
      int gap;
      send_sample(px, py, ax, ay, bx, by, cx, cy);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   // Field extremes, degenerate triangles and saturating weights
   task automatic test_directed();
      coord_type mx, mn;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      // right triangle, point at each vertex, inside and outside
      send_with_gap(16, 16, 160, 0, 0, 160, 0, 0);
      send_with_gap(160, 0, 160, 0, 0, 160, 0, 0);
      send_with_gap(0, 160, 160, 0, 0, 160, 0, 0);
      send_with_gap(0, 0, 160, 0, 0, 160, 0, 0);
      send_with_gap(-16, 16, 160, 0, 0, 160, 0, 0);
      send_with_gap(200, 200, 160, 0, 0, 160, 0, 0);
      // clockwise winding gives a negative determinant
      send_with_gap(16, 16, 0, 160, 160, 0, 0, 0);
      // degenerate: all vertices equal, collinear
      send_with_gap(5, 7, 3, 3, 3, 3, 3, 3);
      send_with_gap(mx, mn, 0, 0, 16, 16, 32, 32);
      send_with_gap(0, 0, mx, mx, mx, mx, mx, mx);
      // tiny triangle, far point: weights saturate both ways
      send_with_gap(mx, mx, 1, 0, 0, 1, 0, 0);
      send_with_gap(mn, mn, 1, 0, 0, 1, 0, 0);
      send_with_gap(mn, mx, 1, 0, 0, 1, 0, 0);
      send_with_gap(mx, mn, 0, 1, 1, 0, 0, 0);
      // largest triangle, extreme coordinates
      send_with_gap(0, 0, mx, mn, mn, mn, mn, mx);
      send_with_gap(mn, mn, mx, mx, mn, mx, mx, mn);
      send_with_gap(mx, mx, mn, mn, mx, mn, mn, mx);
      send_with_gap(-1, -1, mx, 0, 0, mx, mn, mn);
      send_with_gap(mx, mx, mx, mn, mn, mx, mn, mn);
      send_with_gap(mn, mn, mn, mx, mx, mn, mx, mx);
   endtask

   // Mix of full-range triangles, small triangles near the point, and
   // degenerate ones with random content
   task automatic test_random();
      coord_type px, py, ax, ay, bx, by, cx, cy;
      int        kind, span;
      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(0, 9);
         px = rand_coord();  py = rand_coord();
         ax = rand_coord();  ay = rand_coord();
         bx = rand_coord();  by = rand_coord();
         cx = rand_coord();  cy = rand_coord();
         if (kind < 5) begin
            // local triangle so that weights stay mostly in range
            span = (kind < 2) ? 64 : 2048;
            cx = $urandom_range(0, 8000) - 4000;
            cy = $urandom_range(0, 8000) - 4000;
            ax = cx + $signed($urandom_range(0, 2 * span)) - span;
            ay = cy + $signed($urandom_range(0, 2 * span)) - span;
            bx = cx + $signed($urandom_range(0, 2 * span)) - span;
            by = cy + $signed($urandom_range(0, 2 * span)) - span;
            px = cx + $signed($urandom_range(0, 2 * span)) - span;
            py = cy + $signed($urandom_range(0, 2 * span)) - span;
         end else if (kind == 5) begin
            // collinear vertices
            ax = cx + 2 * (bx - cx);
            ay = cy + 2 * (by - cy);
            if ($urandom_range(0, 1)) begin
               bx = cx;  by = cy;
            end
         end
         send_with_gap(px, py, ax, ay, bx, by, cx, cy);
         if (i == N_RANDOM / 2) rsp_stall_on = 1'b0;
         if (i == N_RANDOM / 2 + 150) rsp_stall_on = 1'b1;
      end
      req_valid <= 1'b0;
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      int gap;
      if (reset || !rsp_stall_on) begin
         rsp_ready <= !reset;
      end else begin
         gap = pick_gap();
         rsp_ready <= (gap == 0);
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      weights_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_weights.size() == 0) begin
            $error("result transfer with nothing expected");
            n_errors++;
         end else begin
            w = expected_weights.pop_front();
            n_checked++;
            if (rsp_alpha !== w.alpha) begin
               $error("alpha: expected %0d, got %0d", w.alpha, rsp_alpha);
               n_errors++;
            end
            if (rsp_beta !== w.beta) begin
               $error("beta: expected %0d, got %0d", w.beta, rsp_beta);
               n_errors++;
            end
            if (rsp_gamma !== w.gamma) begin
               $error("gamma: expected %0d, got %0d", w.gamma, rsp_gamma);
               n_errors++;
            end
            if (rsp_inside_res !== w.inside_res) begin
               $error("inside_res: expected %0b, got %0b", w.inside_res, rsp_inside_res);
               n_errors++;
            end
            if (rsp_degenerate !== w.degenerate) begin
               $error("degenerate: expected %0b, got %0b", w.degenerate, rsp_degenerate);
               n_errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no transfer in %0d cycles", WDOG_MAX);
            $display("tb_triangle_barycentric_coords_unit: FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("covered %0d samples, %0d checked: %0d degenerate, %0d inside,",
               n_sent, n_checked, n_degen, n_inside);
      $display("  %0d with a saturated alpha", n_sat);
      if (n_errors == 0 && expected_weights.size() == 0) begin
         $display("tb_triangle_barycentric_coords_unit: PASS");
      end else begin
         $display("tb_triangle_barycentric_coords_unit: FAIL");
      end
      $finish;
   end

endmodule

// ===== triangle_barycentric_coords_unit.f =====
design/tbc_pkg.sv
design/tbc_front.sv
design/tbc_div_cell.sv
design/triangle_barycentric_coords_unit.sv
design/tbc_checker.sv
bench/tb_triangle_barycentric_coords_unit.sv
